@@ src/sfla_pkg.sv @@
package sfla_pkg;

  // Default pool capacity and the fixed field widths of the interface.
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned SLOT_W       = 10;
  localparam int unsigned COUNT_W      = 11;

  // Reset value of the pool size register.
  localparam logic [COUNT_W-1:0] POOL_SLOTS_RST = COUNT_W'(1024);

  // Depth of the queue between the front and back parts (a power of two).
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_FREE   = 2'd1,
    FUNC_EXISTS = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // A classified operation, as it travels from the front to the back.
  typedef struct packed {
    func_t             func;
    logic [SLOT_W-1:0] idx;
    logic              oor;
  } op_t;

  // One result item.
  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  granted;
    logic               is_alloc;
    logic [COUNT_W-1:0] live;
    logic [COUNT_W-1:0] high_water;
  } result_t;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_EXEC = 1'b1
  } back_state_t;

endpackage

@@ src/sfla_front.sv @@
module sfla_front #(
  parameter int unsigned CAPACITY = sfla_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfla_pkg::COUNT_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [sfla_pkg::SLOT_W-1:0]   in_slot_index,
  output logic                          push_valid,
  input  logic                          push_ready,
  output sfla_pkg::op_t                 push_op,
  output logic [sfla_pkg::COUNT_W-1:0]  bound
);
  import sfla_pkg::*;

  // The pool size register can never name more than the counters can hold.
  localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int unsigned CAP_CLIP  = (CAPACITY > COUNT_MAX) ? COUNT_MAX : CAPACITY;
  localparam logic [COUNT_W-1:0] CAP_BOUND = COUNT_W'(CAP_CLIP);

  logic [COUNT_W-1:0] pool_slots_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_slots_r <= POOL_SLOTS_RST;
    end else if (cfg_we) begin
      pool_slots_r <= cfg_wdata;
    end
  end

  // The effective bound saturates at the capacity of the mark store.
  assign bound = (pool_slots_r > CAP_BOUND) ? CAP_BOUND : pool_slots_r;

  assign in_ready      = push_ready;
  assign push_valid    = in_valid;
  assign push_op.func  = func_t'(in_func);
  assign push_op.idx   = in_slot_index;
  assign push_op.oor   = ({1'b0, in_slot_index} >= bound);

endmodule

@@ src/sfla_queue.sv @@
module sfla_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  sfla_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop,
  output sfla_pkg::op_t pop_op
);
  import sfla_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);

  op_t              entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_op     = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_ONE;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_ONE;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_ONE;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

@@ src/sfla_back.sv @@
module sfla_back #(
  parameter int unsigned CAPACITY = sfla_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sfla_pkg::COUNT_W-1:0]  bound,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  sfla_pkg::op_t                 q_op,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sfla_pkg::result_t             res
);
  import sfla_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [COUNT_W-1:0] ONE = COUNT_W'(1);

  // Allocated marks and the stack of recycled slots.
  logic              mark_mem [CAPACITY];
  logic [SLOT_W-1:0] stk_mem  [CAPACITY];

  back_state_t        state_r, state_nxt;
  op_t                op_r;
  logic               mark_rd_r;
  logic [SLOT_W-1:0]  stk_rd_r;
  logic               out_valid_r, out_valid_nxt;
  result_t            res_r, res_nxt;
  logic [COUNT_W-1:0] depth_r, depth_nxt;
  logic [COUNT_W-1:0] bump_r, bump_nxt;
  logic [COUNT_W-1:0] live_r, live_nxt;

  logic               rd_en;
  logic               commit;
  logic               mark_cur;
  logic               mark_we;
  logic [AW-1:0]      mark_wa;
  logic               mark_wd;
  logic               stk_we;
  logic [AW-1:0]      stk_wa;
  status_t            status;
  logic [SLOT_W-1:0]  granted;
  logic               is_alloc;

  // Sequencer: fetch the memory words in idle, then execute once the output register is free.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          rd_en     = 1'b1;
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        if (!out_valid_r || out_ready) begin
          commit    = 1'b1;
          state_nxt = B_IDLE;
        end
      end
    endcase
  end

  // Marks at or above the bump pointer were not written since the last clear
  // and therefore read as zero.
  assign mark_cur = mark_rd_r && ({1'b0, op_r.idx} < bump_r);

  always_comb begin
    status    = ST_OK;
    granted   = '0;
    is_alloc  = 1'b0;
    depth_nxt = depth_r;
    bump_nxt  = bump_r;
    live_nxt  = live_r;
    mark_we   = 1'b0;
    mark_wa   = AW'(op_r.idx);
    mark_wd   = 1'b0;
    stk_we    = 1'b0;
    stk_wa    = AW'(depth_r);
    unique case (op_r.func)
      FUNC_ALLOC: begin
        priority if (depth_r != '0) begin
          depth_nxt = depth_r - ONE;
          granted   = stk_rd_r;
          is_alloc  = 1'b1;
          mark_we   = 1'b1;
          mark_wa   = AW'(stk_rd_r);
          mark_wd   = 1'b1;
          live_nxt  = live_r + ONE;
        end else if (bump_r < bound) begin
          bump_nxt  = bump_r + ONE;
          granted   = bump_r[SLOT_W-1:0];
          is_alloc  = 1'b1;
          mark_we   = 1'b1;
          mark_wa   = AW'(bump_r);
          mark_wd   = 1'b1;
          live_nxt  = live_r + ONE;
        end else begin
          status    = ST_FULL;
        end
      end
      FUNC_FREE: begin
        priority if (op_r.oor) begin
          status    = ST_RANGE;
        end else if (!mark_cur) begin
          status    = ST_NOT_ALLOC;
        end else begin
          mark_we   = 1'b1;
          stk_we    = 1'b1;
          depth_nxt = depth_r + ONE;
          if (live_r != '0) begin
            live_nxt = live_r - ONE;
          end
        end
      end
      FUNC_EXISTS: begin
        if (op_r.oor) begin
          status   = ST_RANGE;
        end else begin
          is_alloc = mark_cur;
        end
      end
      FUNC_CLEAR: begin
        depth_nxt = '0;
        bump_nxt  = '0;
        live_nxt  = '0;
      end
    endcase
  end

  always_comb begin
    res_nxt.status     = status;
    res_nxt.granted    = granted;
    res_nxt.is_alloc   = is_alloc;
    res_nxt.live       = live_nxt;
    res_nxt.high_water = bump_nxt;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
      bump_r      <= '0;
      live_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        depth_r <= depth_nxt;
        bump_r  <= bump_nxt;
        live_r  <= live_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= q_op;
    end
    if (commit) begin
      res_r <= res_nxt;
    end
  end

  // Mark store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (commit && mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    if (rd_en) begin
      mark_rd_r <= mark_mem[AW'(q_op.idx)];
    end
  end

  // Recycle stack: push at the depth, the top word is read ahead of use.
  always_ff @(posedge clk) begin
    if (commit && stk_we) begin
      stk_mem[stk_wa] <= op_r.idx;
    end
    if (rd_en) begin
      stk_rd_r <= stk_mem[AW'(depth_r - ONE)];
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

@@ src/slot_free_list_allocator.sv @@
// Slot allocator over a pool of CAPACITY indices with a last-in first-out
// free list. Each item carries an operation: allocate hands out the most
// recently freed slot, or failing that the next never-used slot from a bump
// pointer below the configured pool size, and reports pool full otherwise;
// free releases an allocated slot and pushes it for reuse; exists reads one
// allocated mark; clear empties the pool at once, without a sweep, because
// marks at or above the bump pointer always read as zero. Every result item
// carries the live count and the high-water mark. The pool size register may
// be written only while the block is idle; a write keeps the pool state.
// In the back end an item goes through two steps, first reading the mark and
// the stack top from the registered memory ports, then executing and writing
// back, and a new item is fetched only once the last one is done. A two-entry
// queue lets the input side keep accepting items while a result waits to
// be taken, and there is no clearing pass after reset.
module slot_free_list_allocator #(
  parameter int unsigned CAPACITY = sfla_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfla_pkg::COUNT_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [sfla_pkg::SLOT_W-1:0]   in_slot_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [sfla_pkg::SLOT_W-1:0]   out_granted_slot,
  output logic                          out_is_allocated,
  output logic [sfla_pkg::COUNT_W-1:0]  out_live_count,
  output logic [sfla_pkg::COUNT_W-1:0]  out_high_water
);
  import sfla_pkg::*;

  logic               push_valid;
  logic               push_ready;
  op_t                push_op;
  logic               q_valid;
  logic               q_pop;
  op_t                q_op;
  logic [COUNT_W-1:0] bound;
  result_t            res;

  // The front holds the pool size and classifies each item, flagging an
  // index that lies outside the effective bound.
  sfla_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_slot_index (in_slot_index),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_op       (push_op),
    .bound         (bound)
  );

  // The queue decouples acceptance from execution.
  sfla_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_op     (q_op)
  );

  // The back owns the mark store, the recycle stack and the counters, and
  // holds each result in its output register until it is taken.
  sfla_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .bound     (bound),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_op      (q_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_status       = res.status;
  assign out_granted_slot = res.granted;
  assign out_is_allocated = res.is_alloc;
  assign out_live_count   = res.live;
  assign out_high_water   = res.high_water;

  // Every allocated slot was once handed out by the bump pointer.
  a_live_within_high_water: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_live_count <= out_high_water)
  ) else $error("live count exceeds high-water mark");

  // A failed allocate grants nothing.
  a_full_grants_nothing: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |->
      ((out_granted_slot == '0) && !out_is_allocated)
  ) else $error("pool-full result carries a grant");

  // An out-of-range index never reports an allocated mark.
  a_range_not_allocated: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_RANGE)) |->
      (!out_is_allocated && (out_granted_slot == '0))
  ) else $error("out-of-range result reports an allocated slot");

endmodule

@@ dv/slot_free_list_allocator_test.sv @@
module slot_free_list_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sfla_pkg::*;

  // The pool capacity of the block as built, and the number of cycles in
  // which nothing may move before the run is given up as hung.
  localparam int unsigned CAP = CAPACITY_DEF;
  localparam int unsigned HANG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 1450;

  // One request to the allocator as it waits to be driven.
  typedef struct {
    func_t             op;
    logic [SLOT_W-1:0] slot;
  } slot_req_t;

  // The reply that the allocator owes for one accepted request.
  typedef struct {
    status_t            status;
    logic [SLOT_W-1:0]  granted;
    logic               marked;
    logic [COUNT_W-1:0] live;
    logic [COUNT_W-1:0] high;
  } slot_reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_func = FUNC_ALLOC;
  logic [SLOT_W-1:0]  in_slot_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [SLOT_W-1:0]  out_granted_slot;
  logic               out_is_allocated;
  logic [COUNT_W-1:0] out_live_count;
  logic [COUNT_W-1:0] out_high_water;

  slot_free_list_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_slot_index    (in_slot_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_granted_slot (out_granted_slot),
    .out_is_allocated (out_is_allocated),
    .out_live_count   (out_live_count),
    .out_high_water   (out_high_water)
  );

  always #5 clk = ~clk;

  // Requests waiting for the driver, and the replies owed by the block in
  // the order in which their requests were accepted.
  slot_req_t   pending_reqs[$];
  slot_reply_t replies_due[$];

  // Handshake bookkeeping. Each counter has exactly one writer, so the
  // clocked blocks on the rising and falling edges never race on them.
  int unsigned items_sent = 0;
  int unsigned items_accepted = 0;
  int unsigned results_taken = 0;
  int unsigned results_noted = 0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  int unsigned send_gap_max = 0;
  int unsigned take_gap_max = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned mismatch_count = 0;

  // Our own copy of the allocator: the pool size register, the allocated
  // marks, the recycle stack with its depth, the bump pointer and the live
  // count. The register is updated by the stimulus only while the block is
  // idle; everything else moves as requests are accepted.
  logic [COUNT_W-1:0] pool_size = POOL_SLOTS_RST;
  bit                 slot_marked[CAP];
  logic [SLOT_W-1:0]  recycle_stack[CAP];
  int unsigned        recycle_depth = 0;
  int unsigned        bump_ptr = 0;
  int unsigned        live_total = 0;

  // The pool size saturates at the capacity of the block.
  function automatic int unsigned usable_slots();
    return (pool_size > CAP) ? CAP : pool_size;
  endfunction

  // Applies one request to the model of the pool and returns the reply that
  // the block must give for it.
  function automatic slot_reply_t apply_slot_op(func_t op, logic [SLOT_W-1:0] idx);
    slot_reply_t r;
    int unsigned lim;
    lim = usable_slots();
    r.status = ST_OK;
    r.granted = '0;
    r.marked = 1'b0;
    case (op)
      FUNC_ALLOC: begin
        // A recycled slot is preferred, even when a shrunken pool now puts
        // it out of range; only then is a fresh slot taken from the bump
        // pointer.
        if (recycle_depth > 0) begin
          recycle_depth--;
          r.granted = recycle_stack[recycle_depth];
        end else if (bump_ptr < lim) begin
          r.granted = SLOT_W'(bump_ptr);
          bump_ptr++;
        end else begin
          r.status = ST_FULL;
        end
        if (r.status == ST_OK) begin
          slot_marked[r.granted] = 1'b1;
          live_total++;
          r.marked = 1'b1;
        end
      end
      FUNC_FREE: begin
        if (idx >= lim) begin
          r.status = ST_RANGE;
        end else if (!slot_marked[idx]) begin
          r.status = ST_NOT_ALLOC;
        end else begin
          slot_marked[idx] = 1'b0;
          if (recycle_depth < CAP) begin
            recycle_stack[recycle_depth] = idx;
            recycle_depth++;
          end
          if (live_total > 0) live_total--;
        end
      end
      FUNC_EXISTS: begin
        if (idx >= lim) r.status = ST_RANGE;
        else r.marked = slot_marked[idx];
      end
      default: begin
        foreach (slot_marked[i]) slot_marked[i] = 1'b0;
        recycle_depth = 0;
        bump_ptr = 0;
        live_total = 0;
      end
    endcase
    r.live = COUNT_W'(live_total);
    r.high = COUNT_W'(bump_ptr);
    return r;
  endfunction

  // Driver. Inputs change on the falling edge only. When the item on the
  // port has been taken, the gap before the next one is drawn; valid is
  // computed once and assigned once per edge, so back-to-back items keep it
  // high without a glitch.
  always @(negedge clk) begin
    logic present;
    slot_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      present = in_valid;
      if (in_valid && items_sent == items_accepted) begin
        present = 1'b0;
        send_gap = $urandom_range(0, send_gap_max);
      end
      if (!present) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0) begin
          req = pending_reqs.pop_front();
          in_func <= req.op;
          in_slot_index <= req.slot;
          items_sent++;
          present = 1'b1;
        end
      end
      in_valid <= present;
    end
  end

  // Result side back-pressure: after each result item a fresh stall length
  // is drawn, and ready stays low until it has run out.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (results_taken != results_noted) begin
        results_noted = results_taken;
        take_gap = $urandom_range(0, take_gap_max);
      end else if (take_gap > 0) begin
        take_gap--;
      end
      out_ready <= (take_gap == 0);
    end
  end

  // Monitor, sampling on the rising edge. An accepted request is run
  // through the model at once; an accepted result is checked against the
  // oldest reply owed. The watchdog counts edges at which neither side
  // moves anything.
  always @(posedge clk) begin
    slot_reply_t want;
    slot_reply_t owed;
    logic moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        owed = apply_slot_op(func_t'(in_func), in_slot_index);
        replies_due.insert(replies_due.size(), owed);
        items_accepted++;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        results_taken++;
        moved = 1'b1;
        if (replies_due.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result item with none outstanding: status %0d slot %0d",
                     $realtime, out_status, out_granted_slot);
        end else begin
          want = replies_due.pop_front();
          if (out_status != want.status || out_granted_slot != want.granted ||
              out_is_allocated != want.marked || out_live_count != want.live ||
              out_high_water != want.high) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: result mismatch, expected status %0d slot %0d mark %0d",
                       $realtime, want.status, want.granted, want.marked);
              $display("  expected live %0d high %0d, got status %0d slot %0d mark %0d",
                       want.live, want.high, out_status, out_granted_slot,
                       out_is_allocated);
              $display("  got live %0d high %0d", out_live_count, out_high_water);
            end
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic queue_op(func_t op, int unsigned idx);
    slot_req_t req;
    req.op = op;
    req.slot = SLOT_W'(idx);
    pending_reqs.insert(pending_reqs.size(), req);
  endtask

  // Holds the stimulus back until every request has been taken and every
  // reply has arrived, then lets the two-stage back end settle.
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || items_sent != items_accepted ||
           replies_due.size() > 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register writes happen only with the block idle; the model's copy of the
  // register changes together with the one in the block.
  task automatic write_pool_size(int unsigned size);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= COUNT_W'(size);
    pool_size = COUNT_W'(size);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic func_t pick_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return FUNC_ALLOC;
    if (r < 75) return FUNC_FREE;
    if (r < 97) return FUNC_EXISTS;
    return FUNC_CLEAR;
  endfunction

  // Most indices are aimed at slots that have been handed out at some point,
  // so that frees and queries find something; the rest straddle the pool
  // bound or cover the whole index range.
  function automatic int unsigned pick_index();
    int unsigned r;
    int unsigned top;
    r = $urandom_range(0, 99);
    if (r < 70 && bump_ptr > 0) return $urandom_range(0, bump_ptr - 1);
    if (r < 90) begin
      top = usable_slots() + 3;
      return $urandom_range(0, (top > CAP - 1) ? CAP - 1 : top);
    end
    return $urandom_range(0, CAP - 1);
  endfunction

  // Pool sizes lean towards small pools, so that the pool fills up and the
  // recycle stack is exercised, with the extremes and the saturating values
  // above the capacity mixed in. Shrinking happens whenever a smaller size
  // follows a larger one with slots still out.
  function automatic int unsigned pick_pool_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 10) return $urandom_range(1, 16);
    if (r < 13) return $urandom_range(17, 64);
    if (r < 15) return CAP;
    if (r == 15) return $urandom_range(CAP + 1, (1 << COUNT_W) - 1);
    if (r == 16) return 0;
    if (r == 17) return $urandom_range(65, CAP - 1);
    return $urandom_range(2, 8);
  endfunction

  initial begin
    int unsigned random_count;
    int unsigned phase_len;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, first with the reset pool size: queries and frees of
    // untouched slots at both ends, fresh allocation, recycling of a freed
    // slot, a double free and a clear.
    send_gap_max = 0;
    take_gap_max = 0;
    queue_op(FUNC_EXISTS, 0);
    queue_op(FUNC_FREE, CAP - 1);
    queue_op(FUNC_ALLOC, 0);
    queue_op(FUNC_ALLOC, CAP - 1);
    queue_op(FUNC_EXISTS, 1);
    queue_op(FUNC_FREE, 0);
    queue_op(FUNC_FREE, 0);
    queue_op(FUNC_ALLOC, 0);
    queue_op(FUNC_EXISTS, CAP - 1);
    queue_op(FUNC_CLEAR, 0);

    // A two-slot pool: fill it, hit the full case, and try indices past the
    // bound.
    write_pool_size(2);
    queue_op(FUNC_ALLOC, 0);
    queue_op(FUNC_ALLOC, 0);
    queue_op(FUNC_ALLOC, 0);
    queue_op(FUNC_FREE, 2);
    queue_op(FUNC_EXISTS, CAP - 1);
    queue_op(FUNC_FREE, 1);

    // Shrink the pool below the freed slot: it must still be handed out
    // again, and after that the pool is full.
    write_pool_size(1);
    queue_op(FUNC_ALLOC, 0);
    queue_op(FUNC_ALLOC, 0);
    queue_op(FUNC_CLEAR, 0);

    // A pool size of zero gives nothing out and puts every index out of
    // range.
    write_pool_size(0);
    queue_op(FUNC_ALLOC, 0);
    queue_op(FUNC_EXISTS, 0);

    // The largest register value saturates to the full capacity.
    write_pool_size((1 << COUNT_W) - 1);
    queue_op(FUNC_EXISTS, CAP - 1);
    queue_op(FUNC_ALLOC, 0);
    queue_op(FUNC_FREE, CAP - 1);

    // Random part, in phases. Each phase sets a pool size and its own gap
    // limits for both sides, a limit of zero giving a stretch at full rate.
    // The queue of pending requests is kept short so that the index hints
    // follow the state of the pool closely.
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      write_pool_size(pick_pool_size());
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      take_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      phase_len = $urandom_range(40, 160);
      repeat (phase_len) begin
        while (pending_reqs.size() >= 3) @(negedge clk);
        // Now and then the sender holds off until the block has drained.
        if ($urandom_range(0, 59) == 0) wait_idle();
        queue_op(pick_func(), pick_index());
        random_count++;
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && replies_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sfla_pkg.sv
src/sfla_front.sv
src/sfla_queue.sv
src/sfla_back.sv
src/slot_free_list_allocator.sv
dv/slot_free_list_allocator_test.sv
